// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file x86alu_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication that is off while reset is held
`define X86_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// same check, always on, also through reset
`define X86_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- rtl/x86alu_pkg.sv -----
// shared types, opcodes and constants of the 8086-style alu
`default_nettype none
package x86alu_pkg;

  localparam int NCELL = 32;

  // flag bit positions
  localparam int FL_C = 0;
  localparam int FL_P = 1;
  localparam int FL_H = 2;
  localparam int FL_Z = 3;
  localparam int FL_S = 4;
  localparam int FL_V = 5;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_ADC  = 5'd1,  OP_SUB  = 5'd2,  OP_SBB = 5'd3,
    OP_AND  = 5'd4,  OP_OR   = 5'd5,  OP_XOR  = 5'd6,  OP_INC = 5'd7,
    OP_DEC  = 5'd8,  OP_NEG  = 5'd9,  OP_NOT  = 5'd10, OP_MUL = 5'd11,
    OP_IMUL = 5'd12, OP_DIV  = 5'd13, OP_IDIV = 5'd14, OP_ROL = 5'd15,
    OP_ROR  = 5'd16, OP_RCL  = 5'd17, OP_RCR  = 5'd18, OP_SHL = 5'd19,
    OP_SAL  = 5'd20, OP_SHR  = 5'd21, OP_SAR  = 5'd22
  } op_t;

  // one item as it travels down the chain
  typedef struct packed {
    logic        w;
    logic        is_div;
    logic        neg_q;
    logic        neg_r;
    logic        derr;
    logic [31:0] res;
    logic [5:0]  flags;
    logic [15:0] dvsr;
    logic [16:0] rem;
    logic [31:0] dvd;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/x86alu_front.sv -----
// entry stage: all non-divide operations and divide operand setup
`default_nettype none
module x86alu_front import x86alu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [4:0]  cmd,
  input  wire logic        word_size,
  input  wire logic [31:0] operand_a,
  input  wire logic [15:0] operand_b,
  input  wire logic [5:0]  flags_in,
  output logic             out_valid,
  output item_t            out_item
);

  logic  valid_r;
  item_t item_r, item_nxt;

  function automatic logic sgn_of(input logic [15:0] v, input logic w);
    return w ? v[15] : v[7];
  endfunction

  function automatic logic [5:0] put_szp(input logic [5:0] f, input logic [15:0] r,
                                         input logic w);
    logic [5:0] g;
    g        = f;
    g[FL_P]  = ~^r[7:0];
    g[FL_Z]  = (r == 16'd0);
    g[FL_S]  = sgn_of(r, w);
    return g;
  endfunction

  // operation decode and flag update
  always_comb begin
    logic        w, c, cin;
    logic [15:0] x, y, mask, r;
    logic [16:0] s17;
    logic [4:0]  h5;
    logic [5:0]  f;
    logic [31:0] prod;
    logic signed [16:0] xs, ys;
    logic signed [33:0] p;
    logic        ov, sa, sy;
    logic [31:0] dv, sdv;
    logic [15:0] ysx;
    logic [4:0]  n, k, nm1;
    logic [17:0] d9;
    logic [33:0] d17;
    logic [8:0]  v9;
    logic [16:0] v17;
    logic [15:0] d8;
    logic [31:0] d16;
    logic [47:0] wide;
    logic [31:0] sx;
    w    = word_size;
    mask = w ? 16'hffff : 16'h00ff;
    x    = operand_a[15:0] & mask;
    y    = operand_b & mask;
    cin  = flags_in[FL_C];
    f    = flags_in;
    n    = operand_b[4:0];
    nm1  = n - 5'd1;
    r    = 16'd0;
    c    = 1'b0;
    s17  = '0; h5 = '0; prod = '0; xs = '0; ys = '0; p = '0; ov = 1'b0;
    sa   = 1'b0; sy = 1'b0; dv = '0; sdv = '0; ysx = '0; k = '0;
    d9   = '0; d17 = '0; v9 = '0; v17 = '0; d8 = '0; d16 = '0; wide = '0; sx = '0;
    item_nxt        = '0;
    item_nxt.w      = w;
    case (op_t'(cmd))
      OP_ADD, OP_ADC: begin
        c   = (op_t'(cmd) == OP_ADC) ? cin : 1'b0;
        s17 = {1'b0, x} + {1'b0, y} + {16'd0, c};
        r   = s17[15:0] & mask;
        f[FL_C] = w ? s17[16] : s17[8];
        h5  = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, c};
        f[FL_H] = h5[4];
        f   = put_szp(f, r, w);
        f[FL_V] = sgn_of((r ^ x) & (r ^ y), w);
      end
      OP_SUB, OP_SBB: begin
        c   = (op_t'(cmd) == OP_SBB) ? cin : 1'b0;
        s17 = {1'b0, x} - {1'b0, y} - {16'd0, c};
        r   = s17[15:0] & mask;
        f[FL_C] = s17[16];
        h5  = {1'b0, x[3:0]} - {1'b0, y[3:0]} - {4'd0, c};
        f[FL_H] = h5[4];
        f   = put_szp(f, r, w);
        f[FL_V] = sgn_of((x ^ y) & (x ^ r), w);
      end
      OP_AND, OP_OR, OP_XOR: begin
        r = (op_t'(cmd) == OP_AND) ? (x & y) : (op_t'(cmd) == OP_OR) ? (x | y) : (x ^ y);
        f[FL_C] = 1'b0;
        f[FL_H] = 1'b0;
        f[FL_V] = 1'b0;
        f = put_szp(f, r, w);
      end
      OP_INC: begin
        r = (x + 16'd1) & mask;
        f[FL_H] = (x[3:0] == 4'hf);
        f = put_szp(f, r, w);
        f[FL_V] = w ? (r == 16'h8000) : (r == 16'h0080);
      end
      OP_DEC: begin
        r = (x - 16'd1) & mask;
        f[FL_H] = (x[3:0] == 4'h0);
        f = put_szp(f, r, w);
        f[FL_V] = w ? (r == 16'h7fff) : (r == 16'h007f);
      end
      OP_NEG: begin
        r = (16'd0 - x) & mask;
        f[FL_C] = (x != 16'd0);
        f[FL_H] = (x[3:0] != 4'h0);
        f = put_szp(f, r, w);
        f[FL_V] = w ? (x == 16'h8000) : (x == 16'h0080);
      end
      OP_NOT: r = ~x & mask;
      OP_MUL: begin
        prod = x * y;
        ov   = w ? (prod[31:16] != 16'd0) : (prod[15:8] != 8'd0);
        f[FL_C] = ov;
        f[FL_V] = ov;
      end
      OP_IMUL: begin
        xs = w ? $signed({x[15], x}) : $signed({{9{x[7]}}, x[7:0]});
        ys = w ? $signed({y[15], y}) : $signed({{9{y[7]}}, y[7:0]});
        p  = xs * ys;
        ov = w ? !((p[33:15] == '0) || (p[33:15] == '1))
               : !((p[33:7] == '0) || (p[33:7] == '1));
        prod = w ? p[31:0] : {16'd0, p[15:0]};
        f[FL_C] = ov;
        f[FL_V] = ov;
      end
      OP_DIV, OP_IDIV: begin
        if (y == 16'd0) begin
          item_nxt.derr = 1'b1;
        end else begin
          item_nxt.is_div = 1'b1;
          dv = w ? operand_a : {16'd0, operand_a[15:0]};
          if (op_t'(cmd) == OP_IDIV) begin
            sa  = w ? operand_a[31] : operand_a[15];
            sdv = w ? operand_a : {{16{operand_a[15]}}, operand_a[15:0]};
            dv  = sa ? (32'd0 - sdv) : sdv;
            sy  = sgn_of(y, w);
            ysx = w ? y : {{8{y[7]}}, y[7:0]};
            item_nxt.dvsr  = sy ? (16'd0 - ysx) : ysx;
            item_nxt.neg_q = sa ^ sy;
            item_nxt.neg_r = sa;
          end else begin
            item_nxt.dvsr = y;
          end
          item_nxt.dvd = dv;
        end
      end
      OP_ROL, OP_ROR: begin
        r = x;
        if (operand_b[3:0] != 4'd0) begin
          d8  = {x[7:0], x[7:0]};
          d16 = {x, x};
          if (op_t'(cmd) == OP_ROL) begin
            d8  = d8 << operand_b[2:0];
            d16 = d16 << operand_b[3:0];
            r   = w ? d16[31:16] : {8'd0, d8[15:8]};
            f[FL_C] = r[0];
          end else begin
            d8  = d8 >> operand_b[2:0];
            d16 = d16 >> operand_b[3:0];
            r   = w ? d16[15:0] : {8'd0, d8[7:0]};
            f[FL_C] = sgn_of(r, w);
          end
          f[FL_V] = sgn_of(x ^ r, w);
        end
      end
      OP_RCL, OP_RCR: begin
        r = x;
        if (n != 5'd0) begin
          if (w) k = (n >= 5'd17) ? n - 5'd17 : n;
          else   k = (n >= 5'd27) ? n - 5'd27 : (n >= 5'd18) ? n - 5'd18 :
                     (n >= 5'd9) ? n - 5'd9 : n;
          v9  = {cin, x[7:0]};
          v17 = {cin, x};
          d9  = {v9, v9};
          d17 = {v17, v17};
          if (op_t'(cmd) == OP_RCL) begin
            d9  = d9 << k;
            d17 = d17 << k;
            v9  = d9[17:9];
            v17 = d17[33:17];
          end else begin
            d9  = d9 >> k;
            d17 = d17 >> k;
            v9  = d9[8:0];
            v17 = d17[16:0];
          end
          r = w ? v17[15:0] : {8'd0, v9[7:0]};
          f[FL_C] = w ? v17[16] : v9[8];
          f[FL_V] = sgn_of(x ^ r, w);
        end
      end
      OP_SHL, OP_SAL: begin
        r = x;
        if (n != 5'd0) begin
          wide = {32'd0, x} << n;
          r    = wide[15:0] & mask;
          f[FL_C] = w ? wide[16] : wide[8];
          f = put_szp(f, r, w);
          f[FL_V] = (op_t'(cmd) == OP_SHL) && sgn_of(x ^ r, w);
        end
      end
      OP_SHR: begin
        r = x;
        if (n != 5'd0) begin
          r = x >> n;
          d16 = {16'd0, x} >> nm1;
          f[FL_C] = d16[0];
          f = put_szp(f, r, w);
          f[FL_V] = sgn_of(x ^ r, w);
        end
      end
      OP_SAR: begin
        r = x;
        if (n != 5'd0) begin
          sx  = w ? {{16{x[15]}}, x} : {{24{x[7]}}, x[7:0]};
          d16 = sx >> n;
          r   = d16[15:0] & mask;
          d16 = sx >> nm1;
          f[FL_C] = d16[0];
          f = put_szp(f, r, w);
          f[FL_V] = 1'b0;
        end
      end
      default: r = 16'd0;
    endcase
    item_nxt.flags = f;
    item_nxt.res   = ((op_t'(cmd) == OP_MUL) || (op_t'(cmd) == OP_IMUL)) ? prod
                                                                      : {16'd0, r};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// ----- rtl/x86alu_cell.sv -----
// one divider cell: a restoring step that yields one quotient bit
`default_nettype none
module x86alu_cell import x86alu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);

  logic  valid_r;
  item_t item_r, item_nxt;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    logic [16:0] sh;
    logic [17:0] diff;
    item_nxt = in_item;
    sh       = {in_item.rem[15:0], in_item.dvd[31]};
    diff     = {1'b0, sh} - {2'b0, in_item.dvsr};
    if (!diff[17]) begin
      item_nxt.rem = diff[16:0];
    end else begin
      item_nxt.rem = sh;
    end
    item_nxt.dvd = {in_item.dvd[30:0], ~diff[17]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// ----- rtl/x86_16bit_alu_with_flags.sv -----
// Top level of the 8086-style alu with flags.
// Input channel in_*: one request per cycle carries opcode, width, operands
// and incoming flags; it is accepted when in_tvalid and in_tready are high.
// Output channel out_*: one result per request, in request order, with the
// updated flags and the divide-error mark.
// Every request, of any opcode, runs through an entry stage, a chain of 32
// divider cells (one quotient bit per cell) and an output register; one
// request is taken each cycle while in_tready is high.
// The whole chain advances together; when the output register holds a
// result the receiver has not taken, the chain freezes and in_tready drops
// until out_tready returns. Requests in flight are never lost.
// Reset (rst_n low, synchronous) empties the chain and the output register;
// the block has no other state and is ready in the first cycle after reset.
`default_nettype none
module x86_16bit_alu_with_flags import x86alu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd[4:0], word_size[5], operand_a[37:6], operand_b[53:38], flags_in[59:54]
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result[31:0], flags_out[37:32], divide_error[38]
  output logic [39:0]      out_tdata
);

  logic        en;
  logic        vld [0:NCELL];
  item_t       itm [0:NCELL];
  logic        out_valid_r;
  logic [39:0] out_data_r, out_data_nxt;

  // chain moves when the output register can take a new result
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  x86alu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .cmd       (in_tdata[4:0]),
    .word_size (in_tdata[5]),
    .operand_a (in_tdata[37:6]),
    .operand_b (in_tdata[53:38]),
    .flags_in  (in_tdata[59:54]),
    .out_valid (vld[0]),
    .out_item  (itm[0])
  );

  // divider chain
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    x86alu_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (vld[g]),
      .in_item   (itm[g]),
      .out_valid (vld[g+1]),
      .out_item  (itm[g+1])
    );
  end

  // sign fixup and packing of quotient and remainder
  always_comb begin
    item_t       it;
    logic [31:0] q;
    logic [15:0] rm, qm;
    logic [31:0] res;
    it = itm[NCELL];
    q  = it.neg_q ? (32'd0 - it.dvd) : it.dvd;
    rm = it.neg_r ? (16'd0 - it.rem[15:0]) : it.rem[15:0];
    qm = q[15:0];
    res = it.w ? {rm, qm} : {16'd0, rm[7:0], qm[7:0]};
    if (!it.is_div) begin
      res = it.res;
    end
    out_data_nxt = {1'b0, it.derr, it.flags, res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[NCELL];
    end
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/x86alu_checker.sv -----
// port-level checks of the alu, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module x86alu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  logic out_stall;
  logic derr_bad;

  assign out_stall = out_tvalid && !out_tready;
  // divide error must come with a zero result and a clear pad bit
  assign derr_bad  = out_tdata[38] && ((out_tdata[31:0] != 32'd0) || out_tdata[39]);

  // a stalled result stays
  `X86_ASSERT_CLK(a_hold_valid, clk, rst_n, out_stall |=> out_tvalid, "result dropped")
  `X86_ASSERT_CLK(a_hold_data, clk, rst_n, out_stall |=> $stable(out_tdata), "result changed")
  // an empty output never blocks the input
  `X86_ASSERT_CLK(a_ready_free, clk, rst_n, !out_tvalid |-> in_tready, "input blocked")
  // divide error forces a zero result
  `X86_ASSERT_CLK(a_derr_zero, clk, rst_n, !(out_tvalid && derr_bad), "bad divide error")
  // reset empties the output register
  `X86_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "valid after reset")

endmodule

bind x86_16bit_alu_with_flags x86alu_checker u_x86alu_checker (.*);
`default_nettype wire

// ----- tb/x86_16bit_alu_with_flags_check.sv -----
// checker for the 8086-style alu: predicts each result and compares it
module x86_16bit_alu_with_flags_check import x86alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [31:0] res;
    logic [5:0]  flags;
    logic        derr;
  } alu_result_t;

  alu_result_t pending_results[$];

  function automatic logic even_par(logic [31:0] v);
    return ~^v[7:0];
  endfunction

  // set parity, zero and sign from a result
  function automatic logic [5:0] with_szp(logic [5:0] f, logic [31:0] r,
                                          logic [31:0] sgn);
    f[FL_P] = even_par(r);
    f[FL_Z] = (r == 0);
    f[FL_S] = (r & sgn) != 0;
    return f;
  endfunction

  function automatic longint sign_ext(logic [31:0] v, logic [31:0] sgn);
    longint s;
    s = longint'({32'd0, v});
    if ((v & sgn) != 0) s = s - longint'({32'd0, sgn}) * 2;
    return s;
  endfunction

  // work out the alu result for one request
  function automatic alu_result_t alu_predict(logic [63:0] d);
    logic [4:0]  op;
    logic        w;
    logic [31:0] a, b, x, y, mask, sgn, dmask, res, sum, rv, dv, sx, q, rr;
    logic [31:0] c, n, rot, obit;
    logic [63:0] wide;
    logic [5:0]  f;
    logic        derr, ov;
    int          bits;
    longint      p, sdv, sdz;
    alu_result_t o;
    op = d[4:0];
    w = d[5];
    a = d[37:6];
    b = {16'd0, d[53:38]};
    f = d[59:54];
    bits = w ? 16 : 8;
    mask = w ? 32'hffff : 32'hff;
    sgn = w ? 32'h8000 : 32'h80;
    dmask = w ? 32'hffffffff : 32'hffff;
    x = a & mask;
    y = b & mask;
    res = 0;
    derr = 0;
    case (op)
      OP_ADD, OP_ADC: begin
        c = (op == OP_ADC) ? {31'd0, f[FL_C]} : 0;
        sum = x + y + c;
        res = sum & mask;
        f[FL_C] = sum > mask;
        f[FL_H] = (x & 15) + (y & 15) + c >= 16;
        f = with_szp(f, res, sgn);
        f[FL_V] = ((res ^ x) & (res ^ y) & sgn) != 0;
      end
      OP_SUB, OP_SBB: begin
        c = (op == OP_SBB) ? {31'd0, f[FL_C]} : 0;
        res = (x - y - c) & mask;
        f[FL_C] = y + c > x;
        f[FL_H] = (y & 15) + c > (x & 15);
        f = with_szp(f, res, sgn);
        f[FL_V] = ((x ^ y) & (x ^ res) & sgn) != 0;
      end
      OP_AND, OP_OR, OP_XOR: begin
        res = (op == OP_AND) ? (x & y) : (op == OP_OR) ? (x | y) : (x ^ y);
        f[FL_C] = 0;
        f[FL_H] = 0;
        f[FL_V] = 0;
        f = with_szp(f, res, sgn);
      end
      OP_INC: begin
        res = (x + 1) & mask;
        f[FL_H] = (x & 15) == 15;
        f = with_szp(f, res, sgn);
        f[FL_V] = res == sgn;
      end
      OP_DEC: begin
        res = (x - 1) & mask;
        f[FL_H] = (x & 15) == 0;
        f = with_szp(f, res, sgn);
        f[FL_V] = res == sgn - 1;
      end
      OP_NEG: begin
        res = (0 - x) & mask;
        f[FL_C] = x != 0;
        f[FL_H] = (x & 15) != 0;
        f = with_szp(f, res, sgn);
        f[FL_V] = x == sgn;
      end
      OP_NOT: res = ~x & mask;
      OP_MUL: begin
        res = x * y;
        f[FL_C] = (res >> bits) != 0;
        f[FL_V] = (res >> bits) != 0;
      end
      OP_IMUL: begin
        p = sign_ext(x, sgn) * sign_ext(y, sgn);
        ov = p < -longint'({32'd0, sgn}) || p > longint'({32'd0, sgn}) - 1;
        res = p[31:0] & dmask;
        f[FL_C] = ov;
        f[FL_V] = ov;
      end
      OP_DIV: begin
        if (y == 0) derr = 1;
        else begin
          dv = a & dmask;
          res = (((dv % y) & mask) << bits) | ((dv / y) & mask);
        end
      end
      OP_IDIV: begin
        if (y == 0) derr = 1;
        else begin
          sdv = sign_ext(a & dmask, w ? 32'h80000000 : 32'h8000);
          sdz = sign_ext(y, sgn);
          q = 32'(sdv / sdz) & mask;
          rr = 32'(sdv % sdz) & mask;
          res = (rr << bits) | q;
        end
      end
      OP_ROL, OP_ROR: begin
        n = b & 15;
        res = x;
        if (n != 0) begin
          rot = n % bits;
          if (rot != 0)
            res = (op == OP_ROL) ? ((x << rot) | (x >> (bits - rot))) & mask
                                 : ((x >> rot) | (x << (bits - rot))) & mask;
          f[FL_C] = (op == OP_ROL) ? res[0] : (res & sgn) != 0;
          f[FL_V] = ((x ^ res) & sgn) != 0;
        end
      end
      OP_RCL, OP_RCR: begin
        n = b & 31;
        res = x;
        if (n != 0) begin
          c = {31'd0, f[FL_C]};
          for (int i = 0; i < n; i++) begin
            if (op == OP_RCL) begin
              obit = ((res & sgn) != 0) ? 1 : 0;
              res = ((res << 1) | c) & mask;
            end else begin
              obit = res & 1;
              res = (c != 0 ? sgn : 0) | (res >> 1);
            end
            c = obit;
          end
          f[FL_C] = c != 0;
          f[FL_V] = ((x ^ res) & sgn) != 0;
        end
      end
      OP_SHL, OP_SAL: begin
        n = b & 31;
        res = x;
        if (n != 0) begin
          wide = {32'd0, x} << n;
          res = wide[31:0] & mask;
          f[FL_C] = wide[bits];
          f = with_szp(f, res, sgn);
          f[FL_V] = (op == OP_SHL) && ((x ^ res) & sgn) != 0;
        end
      end
      OP_SHR: begin
        n = b & 31;
        res = x;
        if (n != 0) begin
          res = x >> n;
          f[FL_C] = x[n - 1];
          f = with_szp(f, res, sgn);
          f[FL_V] = ((x ^ res) & sgn) != 0;
        end
      end
      OP_SAR: begin
        n = b & 31;
        res = x;
        if (n != 0) begin
          sx = x | (((x & sgn) != 0) ? ~mask : 0);
          res = (sx >> n) & mask;
          f[FL_C] = sx[n - 1];
          f = with_szp(f, res, sgn);
          f[FL_V] = 0;
        end
      end
      default: ;
    endcase
    o.res = res;
    o.flags = f;
    o.derr = derr;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = pending_results.size();

  // queue predictions on requests, compare on results
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst_n) begin
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) pending_results.push_back(alu_predict(in_tdata));
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 0);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_tdata[31:0] !== exp_r.res)
            report_mismatch("result", out_tdata[31:0], exp_r.res);
          if (out_tdata[37:32] !== exp_r.flags)
            report_mismatch("flags", {26'd0, out_tdata[37:32]}, {26'd0, exp_r.flags});
          if (out_tdata[38] !== exp_r.derr)
            report_mismatch("divide_error", {31'd0, out_tdata[38]}, {31'd0, exp_r.derr});
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// ----- tb/x86_16bit_alu_with_flags_test.sv -----
// testbench top for the 8086-style alu: stimulus and verdict
module x86_16bit_alu_with_flags_test import x86alu_pkg::*;;

  localparam int LATENCY = 34;
  localparam int RANDOM_COUNT = 1575;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending_count;
  logic        sink_hold;
  logic        sink_calm;
  logic        source_calm;

  x86_16bit_alu_with_flags u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  x86_16bit_alu_with_flags_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // pack one request
  function automatic logic [63:0] pack_req(op_t op, logic w, logic [31:0] a,
                                           logic [15:0] b, logic [5:0] f);
    return {4'd0, f, b, a, w, 5'(op)};
  endfunction

  // offer one request, with random idle cycles unless the source is calm
  task automatic send_req(logic [63:0] d);
    while (!source_calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_rand(int mode);
    logic [4:0]  op;
    logic [31:0] a;
    logic [15:0] b;
    op = 5'($urandom_range(31));
    a = $urandom;
    b = 16'($urandom);
    // mostly defined opcodes, some short counts and small divisors
    if ($urandom_range(9) != 0) op = 5'($urandom_range(22));
    if (mode == 1 || $urandom_range(3) == 0) b = 16'($urandom_range(33));
    if ($urandom_range(4) == 0) a = a >> $urandom_range(31);
    send_req({4'd0, 6'($urandom), b, a, 1'($urandom), op});
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) out_tready <= 1'b0;
      else out_tready <= sink_calm || ($urandom_range(99) >= 10);
    end
  end

  initial begin
    int cycles;
    sink_hold = 0;
    sink_calm = 0;
    source_calm = 0;
    in_tvalid = 0;
    in_tdata = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, every opcode, special cases
    send_req(pack_req(OP_ADD, 1, 32'hffff, 16'hffff, 6'h00));
    send_req(pack_req(OP_ADC, 0, 32'hff, 16'h00, 6'h01));
    send_req(pack_req(OP_SUB, 0, 32'h00, 16'h01, 6'h3f));
    send_req(pack_req(OP_SBB, 1, 32'h8000, 16'hffff, 6'h01));
    send_req(pack_req(OP_AND, 1, 32'hffffffff, 16'h8000, 6'h3f));
    send_req(pack_req(OP_OR, 0, 32'h0, 16'h0, 6'h3f));
    send_req(pack_req(OP_XOR, 1, 32'h5a5a, 16'ha5a5, 6'h00));
    send_req(pack_req(OP_INC, 0, 32'h7f, 16'h0, 6'h01));
    send_req(pack_req(OP_DEC, 1, 32'h8000, 16'h0, 6'h00));
    send_req(pack_req(OP_NEG, 1, 32'h8000, 16'h0, 6'h00));
    send_req(pack_req(OP_NOT, 0, 32'h12345655, 16'h0, 6'h2a));
    send_req(pack_req(OP_MUL, 1, 32'hffff, 16'hffff, 6'h00));
    send_req(pack_req(OP_IMUL, 1, 32'h8000, 16'h8000, 6'h00));
    send_req(pack_req(OP_DIV, 1, 32'hffffffff, 16'h0, 6'h15));
    send_req(pack_req(OP_DIV, 0, 32'hffff, 16'h01, 6'h00));
    send_req(pack_req(OP_IDIV, 1, 32'h80000000, 16'hffff, 6'h00));
    send_req(pack_req(OP_IDIV, 0, 32'hff85, 16'h07, 6'h00));
    send_req(pack_req(OP_ROL, 0, 32'h81, 16'h0, 6'h3f));
    send_req(pack_req(OP_ROR, 0, 32'h81, 16'h8, 6'h00));
    send_req(pack_req(OP_RCL, 1, 32'h8001, 16'h1f, 6'h01));
    send_req(pack_req(OP_RCR, 0, 32'h01, 16'h9, 6'h00));
    send_req(pack_req(OP_SHL, 0, 32'hc0, 16'h1, 6'h00));
    send_req(pack_req(OP_SAL, 1, 32'h4000, 16'h1, 6'h20));
    send_req(pack_req(OP_SHR, 1, 32'h8000, 16'h11, 6'h00));
    send_req(pack_req(OP_SAR, 1, 32'h8000, 16'h1f, 6'h00));
    send_req({4'd0, 6'h3f, 16'hffff, 32'hffffffff, 1'b1, 5'd31});
    in_tvalid <= 1'b0;
    // pause until every result is back
    while (pending_count != 0) @(posedge clk);
    // long hold-off on the receiver while requests keep coming
    fork
      begin
        sink_hold = 1;
        for (cycles = 0; cycles < 120; cycles++) @(posedge clk);
        sink_hold = 0;
      end
      begin
        source_calm = 1;
        repeat (150) send_rand(1);
        source_calm = 0;
      end
    join
    // random part, with one stretch without idling
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      sink_calm = (i >= 600 && i < 900);
      source_calm = sink_calm;
      send_rand(0);
    end
    sink_calm = 0;
    source_calm = 0;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("x86_16bit_alu_with_flags_test: PASS");
    else $display("x86_16bit_alu_with_flags_test: FAIL");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("x86_16bit_alu_with_flags_test: FAIL");
    $finish;
  end

endmodule
